FILE: hw/rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define GWT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define GWT_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define GWT_ASSERT(label, clk, rst_n, prop)

`define GWT_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

FILE: hw/rtl/gwt_pkg.sv
package gwt_pkg;

    typedef logic [1:0] opcode_t;
    typedef logic [1:0] status_t;

    localparam opcode_t OP_UPDATE = 2'd0;
    localparam opcode_t OP_GWRITE = 2'd1;
    localparam opcode_t OP_TWRITE = 2'd2;
    localparam opcode_t OP_TREAD  = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EQUAL = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

    localparam int FRAC_W    = 16;
    localparam int WEIGHT_W  = FRAC_W + 1;
    localparam int DIV_STEPS = WEIGHT_W;

    typedef logic [WEIGHT_W-1:0] weight_t;

    localparam weight_t FRAC_ONE = weight_t'(1) << FRAC_W;

endpackage

FILE: hw/rtl/gwt_div.sv
module gwt_div
    import gwt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [FRAC_W-1:0]   num,
    input  logic [FRAC_W-1:0]   den,
    output logic                done,
    output weight_t             quot
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [FRAC_W:0]     rem_reg;
    logic [FRAC_W-1:0]   den_reg;
    weight_t             q_reg;

    logic                ge;
    logic [FRAC_W:0]     sub;
    logic [FRAC_W:0]     rem_next;

    // one quotient bit a cycle, numerator implicitly shifted up by the fraction width
    always_comb
    begin
        ge       = rem_reg >= {1'b0, den_reg};
        sub      = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_next = {sub[FRAC_W-1:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= {1'b0, num};
                den_reg  <= den;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                q_reg   <= {q_reg[WEIGHT_W-2:0], ge};
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

FILE: hw/rtl/gwt_blend.sv
module gwt_blend
    import gwt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  entry,
    input  logic signed [31:0]  val,
    input  weight_t             weight,
    output logic                done,
    output logic signed [31:0]  result
);

    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic signed [32:0] diff_reg;
    weight_t            w_reg;
    logic signed [31:0] val1_reg;
    logic signed [31:0] val2_reg;
    logic signed [50:0] prod_reg;
    logic signed [31:0] res_reg;

    logic signed [32:0] diff_next;
    logic signed [50:0] prod_next;
    logic signed [31:0] res_next;

    always_comb
    begin
        diff_next = {entry[31], entry} - {val[31], val};
        prod_next = diff_reg * signed'({1'b0, w_reg});
        // arithmetic shift of the product rounds toward minus infinity
        res_next  = val2_reg + prod_reg[47:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            diff_reg <= diff_next;
            w_reg    <= weight;
            val1_reg <= val;
        end
        if (v1_reg)
        begin
            prod_reg <= prod_next;
            val2_reg <= val1_reg;
        end
        if (v2_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = v3_reg;
    assign result = res_reg;

endmodule

FILE: hw/rtl/grid_weighted_table_update_unit.sv
// Grid-weighted table update: holds ENTRIES grid points and ENTRIES Q16.16 table
// values in two memories, each with one write port and one registered read port.
// One item is taken at a time; stall stays high until its result has been formed.
// An update scans the grid one point a cycle; beyond the last point it overwrites
// the last entry. Otherwise, unless the two bracketing grid points are equal, it
// runs a serial divider for the fraction (skipped at or below the first point) and
// two multiply passes through one shared blend unit.
// Results sit in an output register, so a new item may be taken while one waits.
`include "assert_macros.svh"

module grid_weighted_table_update_unit
    import gwt_pkg::*;
#(
    parameter int ENTRIES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               stall,
    input  logic [1:0]         opcode,
    input  logic [2:0]         entry_index,
    input  logic [15:0]        soc,
    input  logic signed [31:0] value,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] read_value,
    output logic [2:0]         left_entry,
    output logic [2:0]         right_entry,
    output logic [1:0]         status
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST  = IW'(ENTRIES - 1);
    localparam logic [2:0]    LAST3 = 3'(ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_CHECK0,
        S_CHECK,
        S_DIV,
        S_TREAD,
        S_BSTART,
        S_BWAIT,
        S_RDATA,
        S_FINISH
    } state_t;

    state_t             state_reg;

    logic [15:0]        grid_mem [ENTRIES];
    logic signed [31:0] table_mem [ENTRIES];
    logic [15:0]        g_rdata_reg;
    logic signed [31:0] t_rdata_reg;

    logic [15:0]        soc_reg;
    logic signed [31:0] val_reg;
    logic [IW-1:0]      i_reg;
    logic [IW-1:0]      l_reg;
    logic [IW-1:0]      r_reg;
    logic [15:0]        prev_reg;
    logic [15:0]        gl_reg;
    logic [15:0]        gr_reg;
    logic               first_reg;
    logic               side_reg;
    weight_t            alpha_reg;

    logic signed [31:0] res_read_reg;
    logic [2:0]         res_left_reg;
    logic [2:0]         res_right_reg;
    status_t            res_status_reg;

    logic               result_valid_reg;
    logic signed [31:0] read_value_reg;
    logic [2:0]         left_entry_reg;
    logic [2:0]         right_entry_reg;
    status_t            status_reg;

    logic               accept;
    logic [IW+2:0]      in_idx_ext;
    logic [IW-1:0]      in_idx;
    logic               in_range;
    logic               found;
    logic [IW-1:0]      i_next;
    logic [IW+2:0]      l_ext;
    logic [IW+2:0]      r_ext;
    weight_t            beta;

    logic [IW-1:0]      g_raddr;
    logic [IW-1:0]      t_raddr;
    logic               g_we;
    logic               t_we;
    logic [IW-1:0]      t_waddr;
    logic signed [31:0] t_wdata;

    logic               div_start;
    logic               div_done;
    weight_t            div_quot;
    logic               blend_start;
    logic               blend_done;
    logic signed [31:0] blend_result;

    always_comb
    begin
        accept      = valid && !stall;
        in_idx_ext  = {{IW{1'b0}}, entry_index};
        in_idx      = in_idx_ext[IW-1:0];
        in_range    = in_idx_ext < (IW+3)'(ENTRIES);
        found       = g_rdata_reg >= soc_reg;
        i_next      = (i_reg == LAST) ? '0 : (i_reg + IW'(1));
        l_ext       = {3'b000, l_reg};
        r_ext       = {3'b000, r_reg};
        beta        = FRAC_ONE - alpha_reg;
        div_start   = (state_reg == S_CHECK) && (gr_reg != gl_reg) && !first_reg;
        blend_start = state_reg == S_BSTART;
    end

    // memory port control
    always_comb
    begin
        g_raddr = '0;
        t_raddr = l_reg;
        g_we    = 1'b0;
        t_we    = 1'b0;
        t_waddr = in_idx;
        t_wdata = value;
        unique case (state_reg)
            S_IDLE:
            begin
                t_raddr = in_idx;
                g_we    = accept && in_range && (opcode == OP_GWRITE);
                t_we    = accept && in_range && (opcode == OP_TWRITE);
            end
            S_SEARCH:
            begin
                g_raddr = i_next;
                // soc beyond the last point overwrites the last entry
                if (!found && (i_reg == LAST))
                begin
                    t_we    = 1'b1;
                    t_waddr = LAST;
                    t_wdata = val_reg;
                end
            end
            S_TREAD:
            begin
                t_raddr = side_reg ? r_reg : l_reg;
            end
            S_BWAIT:
            begin
                t_we    = blend_done;
                t_waddr = side_reg ? r_reg : l_reg;
                t_wdata = blend_result;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            grid_mem[in_idx] <= soc;
        end
        g_rdata_reg <= grid_mem[g_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            table_mem[t_waddr] <= t_wdata;
        end
        t_rdata_reg <= table_mem[t_raddr];
    end

    gwt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (soc_reg - gl_reg),
        .den   (gr_reg - gl_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    gwt_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (blend_start),
        .entry  (t_rdata_reg),
        .val    (val_reg),
        .weight (side_reg ? beta : alpha_reg),
        .done   (blend_done),
        .result (blend_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            soc_reg          <= '0;
            val_reg          <= '0;
            i_reg            <= '0;
            l_reg            <= '0;
            r_reg            <= '0;
            prev_reg         <= '0;
            gl_reg           <= '0;
            gr_reg           <= '0;
            first_reg        <= 1'b0;
            side_reg         <= 1'b0;
            alpha_reg        <= '0;
            res_read_reg     <= '0;
            res_left_reg     <= '0;
            res_right_reg    <= '0;
            res_status_reg   <= ST_OK;
            result_valid_reg <= 1'b0;
            read_value_reg   <= '0;
            left_entry_reg   <= '0;
            right_entry_reg  <= '0;
            status_reg       <= ST_OK;
        end
        else
        begin
            // in S_FINISH a taken result is always replaced by the next one
            if (result_valid_reg && !result_stall && (state_reg != S_FINISH))
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        soc_reg        <= soc;
                        val_reg        <= value;
                        i_reg          <= '0;
                        res_read_reg   <= '0;
                        res_left_reg   <= '0;
                        res_right_reg  <= '0;
                        priority if (opcode == OP_UPDATE)
                        begin
                            res_status_reg <= ST_OK;
                            state_reg      <= S_SEARCH;
                        end
                        else if (!in_range)
                        begin
                            res_status_reg <= ST_RANGE;
                            state_reg      <= S_FINISH;
                        end
                        else if (opcode == OP_TREAD)
                        begin
                            res_status_reg <= ST_OK;
                            state_reg      <= S_RDATA;
                        end
                        else
                        begin
                            res_status_reg <= ST_OK;
                            state_reg      <= S_FINISH;
                        end
                    end
                end
                S_SEARCH:
                begin
                    prev_reg <= g_rdata_reg;
                    priority if (found)
                    begin
                        if (i_reg == '0)
                        begin
                            // at or below the first point: alpha is zero, so no division follows the pair check
                            l_reg     <= '0;
                            r_reg     <= IW'(1);
                            gl_reg    <= g_rdata_reg;
                            first_reg <= 1'b1;
                            state_reg <= S_CHECK0;
                        end
                        else
                        begin
                            l_reg     <= i_reg - IW'(1);
                            r_reg     <= i_reg;
                            gl_reg    <= prev_reg;
                            gr_reg    <= g_rdata_reg;
                            first_reg <= 1'b0;
                            state_reg <= S_CHECK;
                        end
                    end
                    else if (i_reg == LAST)
                    begin
                        res_left_reg  <= LAST3;
                        res_right_reg <= LAST3;
                        state_reg     <= S_FINISH;
                    end
                    else
                    begin
                        i_reg <= i_next;
                    end
                end
                S_CHECK0:
                begin
                    // second grid point was read while the first was compared
                    gr_reg    <= g_rdata_reg;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    res_left_reg  <= l_ext[2:0];
                    res_right_reg <= r_ext[2:0];
                    priority if (gr_reg == gl_reg)
                    begin
                        res_status_reg <= ST_EQUAL;
                        state_reg      <= S_FINISH;
                    end
                    else if (first_reg)
                    begin
                        alpha_reg <= '0;
                        side_reg  <= 1'b0;
                        state_reg <= S_TREAD;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        alpha_reg <= div_quot;
                        side_reg  <= 1'b0;
                        state_reg <= S_TREAD;
                    end
                end
                S_TREAD:
                begin
                    state_reg <= S_BSTART;
                end
                S_BSTART:
                begin
                    state_reg <= S_BWAIT;
                end
                S_BWAIT:
                begin
                    if (blend_done)
                    begin
                        if (!side_reg)
                        begin
                            side_reg  <= 1'b1;
                            state_reg <= S_TREAD;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_RDATA:
                begin
                    res_read_reg <= t_rdata_reg;
                    state_reg    <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        read_value_reg   <= res_read_reg;
                        left_entry_reg   <= res_left_reg;
                        right_entry_reg  <= res_right_reg;
                        status_reg       <= res_status_reg;
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stall        = state_reg != S_IDLE;
    assign result_valid = result_valid_reg;
    assign read_value   = read_value_reg;
    assign left_entry   = left_entry_reg;
    assign right_entry  = right_entry_reg;
    assign status       = status_reg;

    `GWT_ASSERT(a_div_bracket, clk, rst_n, div_start |-> (soc_reg > gl_reg) && (soc_reg <= gr_reg))
    `GWT_ASSERT(a_quot_range, clk, rst_n, div_done |-> (div_quot <= FRAC_ONE))
    `GWT_ASSERT(a_blend_in_wait, clk, rst_n, blend_done |-> (state_reg == S_BWAIT))
    `GWT_ASSERT(a_accept_leaves_idle, clk, rst_n, accept |=> (state_reg != S_IDLE))
    `GWT_ASSERT_NEVER(a_status_code, clk, rst_n, result_valid_reg && (status_reg > ST_RANGE))

endmodule
